// ----- hdl/delta_measurement_log_decoder_defines.svh -----
// Assertion macros for the delta measurement log decoder.
// Used by the top level; needs clk and rst_n in the including scope.
`ifndef DELTA_MEASUREMENT_LOG_DECODER_DEFINES_SVH
`define DELTA_MEASUREMENT_LOG_DECODER_DEFINES_SVH

// same-cycle implication
`define DMLD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dmld assertion failed");

// next-cycle implication
`define DMLD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dmld assertion failed");

`endif

// ----- hdl/dmld_pkg.sv -----
// Shared types and constants of the delta measurement log decoder.
// No dependencies.
package dmld_pkg;

    localparam logic [7:0] CHANNEL_LIMIT = 8'd255;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW = $clog2(FIFO_DEPTH);

    localparam logic [2:0] KIND_SAMPLE = 3'd0;
    localparam logic [2:0] KIND_BATTERY = 3'd1;
    localparam logic [2:0] KIND_BAD_VERSION = 3'd2;
    localparam logic [2:0] KIND_BAD_DELTA = 3'd3;
    localparam logic [2:0] KIND_TRUNCATED = 3'd4;

    // one queue entry: a run of samples, then an optional trailing result
    typedef struct packed {
        logic [4:0]  nsamp;
        logic [4:0]  sl_start;
        logic [22:0] time_start;
        logic [16:0] step;
        logic [15:0] value;
        logic [2:0]  precision;
        logic [7:0]  channel;
        logic        tail_valid;
        logic [2:0]  tail_kind;
        logic [15:0] tail_raw;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fifo_stat_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  channel;
        logic [4:0]  slot;
        logic [22:0] timestamp;
        logic [15:0] raw_value;
        logic [2:0]  precision;
        logic        channel_done;
        logic        last;
    } res_t;

    // x * 60 as x * 64 - x * 4
    function automatic logic [16:0] times60(input logic [10:0] x);
        times60 = {x, 6'd0} - {4'd0, x, 2'd0};
    endfunction

endpackage

// ----- hdl/dmld_front.sv -----
// Front end: byte parser of the log file, one byte per transfer.
// Depends on dmld_pkg; pushes result commands into dmld_fifo.
module dmld_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           data_byte,
    input  logic                 end_of_file,
    input  logic [7:0]           expected_version,
    output logic                 push,
    output dmld_pkg::cmd_t       cmd
);

    localparam logic [3:0] PH_VER  = 4'd0;
    localparam logic [3:0] PH_H0   = 4'd1;
    localparam logic [3:0] PH_H1   = 4'd2;
    localparam logic [3:0] PH_H2   = 4'd3;
    localparam logic [3:0] PH_H3   = 4'd4;
    localparam logic [3:0] PH_FLO  = 4'd5;
    localparam logic [3:0] PH_FHI  = 4'd6;
    localparam logic [3:0] PH_D8   = 4'd7;
    localparam logic [3:0] PH_DLO  = 4'd8;
    localparam logic [3:0] PH_DHI  = 4'd9;
    localparam logic [3:0] PH_HALT = 4'd10;

    logic [3:0]  phase_reg, phase_next;
    logic [31:0] hdr_reg, hdr_next;
    logic [7:0]  lo_reg, lo_next;
    logic [15:0] val_reg, val_next;
    logic [22:0] time_reg, time_next;
    logic [4:0]  sl_reg, sl_next;
    logic [7:0]  cc_reg, cc_next;

    always_comb
    begin
        logic        do_sample;
        logic        finished;
        logic        next_ch;
        logic [22:0] t_start;
        logic [16:0] step60;

        phase_next = phase_reg;
        hdr_next   = hdr_reg;
        lo_next    = lo_reg;
        val_next   = val_reg;
        time_next  = time_reg;
        sl_next    = sl_reg;
        cc_next    = cc_reg;
        cmd        = '0;
        do_sample  = 1'b0;
        finished   = 1'b0;
        next_ch    = 1'b0;
        t_start    = time_reg;
        step60     = dmld_pkg::times60(hdr_reg[21:11]);

        case (phase_reg)
            PH_VER:
            begin
                if (data_byte == expected_version)
                begin
                    phase_next = PH_H0;
                end
                else
                begin
                    cmd.tail_valid = 1'b1;
                    cmd.tail_kind  = dmld_pkg::KIND_BAD_VERSION;
                    phase_next     = PH_HALT;
                end
            end
            PH_H0:
            begin
                if (end_of_file)
                begin
                    cmd.tail_valid = 1'b1;
                    cmd.tail_kind  = dmld_pkg::KIND_BATTERY;
                    cmd.tail_raw   = {8'd0, data_byte};
                    cmd.channel    = cc_reg;
                    finished       = 1'b1;
                end
                else
                begin
                    hdr_next   = {data_byte, hdr_reg[31:8]};
                    phase_next = PH_H1;
                end
            end
            PH_H1:
            begin
                hdr_next   = {data_byte, hdr_reg[31:8]};
                phase_next = PH_H2;
            end
            PH_H2:
            begin
                hdr_next   = {data_byte, hdr_reg[31:8]};
                phase_next = PH_H3;
            end
            PH_H3:
            begin
                hdr_next = {data_byte, hdr_reg[31:8]};
                sl_next  = hdr_next[26:22];
                if (sl_next == 5'd0)
                    next_ch = 1'b1;
                else
                    phase_next = PH_FLO;
            end
            PH_FLO:
            begin
                lo_next    = data_byte;
                phase_next = PH_FHI;
            end
            PH_FHI:
            begin
                val_next  = {data_byte, lo_reg};
                t_start   = {6'd0, dmld_pkg::times60(hdr_reg[10:0])};
                do_sample = 1'b1;
            end
            PH_D8:
            begin
                val_next  = val_reg + {{8{data_byte[7]}}, data_byte};
                do_sample = 1'b1;
            end
            PH_DLO:
            begin
                lo_next    = data_byte;
                phase_next = PH_DHI;
            end
            PH_DHI:
            begin
                val_next  = {data_byte, lo_reg};
                do_sample = 1'b1;
            end
            default:
            begin
            end
        endcase

        if (do_sample)
        begin
            cmd.nsamp      = 5'd1;
            cmd.sl_start   = sl_reg;
            cmd.time_start = t_start;
            cmd.step       = step60;
            cmd.value      = val_next;
            cmd.precision  = hdr_reg[31:29];
            cmd.channel    = cc_reg;
            time_next      = t_start - {6'd0, step60};
            sl_next        = sl_reg - 5'd1;
            if (sl_next == 5'd0)
            begin
                next_ch = 1'b1;
            end
            else
            begin
                case (hdr_reg[28:27])
                    2'd0:
                    begin
                        cmd.nsamp = sl_reg;
                        sl_next   = 5'd0;
                        next_ch   = 1'b1;
                    end
                    2'd1:    phase_next = PH_D8;
                    2'd2:    phase_next = PH_DLO;
                    default:
                    begin
                        cmd.tail_valid = 1'b1;
                        cmd.tail_kind  = dmld_pkg::KIND_BAD_DELTA;
                        phase_next     = PH_HALT;
                    end
                endcase
            end
        end

        if (next_ch)
        begin
            if (cc_reg < dmld_pkg::CHANNEL_LIMIT)
                cc_next = cc_reg + 8'd1;
            phase_next = PH_H0;
        end

        if (end_of_file)
        begin
            if (!finished && phase_next != PH_HALT && phase_next != PH_H0)
            begin
                cmd.tail_valid = 1'b1;
                cmd.tail_kind  = dmld_pkg::KIND_TRUNCATED;
                cmd.channel    = cc_next;
            end
            phase_next = PH_VER;
            hdr_next   = '0;
            lo_next    = '0;
            val_next   = '0;
            time_next  = '0;
            sl_next    = '0;
            cc_next    = '0;
        end

        push = accept && (cmd.nsamp != 5'd0 || cmd.tail_valid);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_VER;
            hdr_reg   <= '0;
            lo_reg    <= '0;
            val_reg   <= '0;
            time_reg  <= '0;
            sl_reg    <= '0;
            cc_reg    <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            hdr_reg   <= hdr_next;
            lo_reg    <= lo_next;
            val_reg   <= val_next;
            time_reg  <= time_next;
            sl_reg    <= sl_next;
            cc_reg    <= cc_next;
        end
    end

endmodule

// ----- hdl/dmld_fifo.sv -----
// Command queue between parser and result generator.
// Depends on dmld_pkg (cmd_t, fifo_stat_t, FIFO_DEPTH).
module dmld_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  dmld_pkg::cmd_t       din,
    input  logic                 pop,
    output dmld_pkg::cmd_t       dout,
    output dmld_pkg::fifo_stat_t stat
);

    dmld_pkg::cmd_t mem [dmld_pkg::FIFO_DEPTH];

    logic [dmld_pkg::FIFO_AW-1:0] wr_reg, rd_reg;
    logic [dmld_pkg::FIFO_AW:0]   cnt_reg;

    assign stat.empty = (cnt_reg == '0);
    assign stat.full  = (cnt_reg == (dmld_pkg::FIFO_AW+1)'(dmld_pkg::FIFO_DEPTH));
    assign dout       = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

// ----- hdl/dmld_back.sv -----
// Back end: expands queued commands into result transfers.
// Depends on dmld_pkg; reads from dmld_fifo.
module dmld_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dmld_pkg::cmd_t       head,
    input  dmld_pkg::fifo_stat_t stat,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output dmld_pkg::res_t       res
);

    dmld_pkg::cmd_t cmd_reg;
    dmld_pkg::cmd_t cur;
    dmld_pkg::res_t res_reg, res_next;
    logic           loaded_reg, loaded_next;
    logic           ov_reg;
    logic [4:0]     rem_reg, sl_reg, cur_rem, cur_sl;
    logic [22:0]    time_reg, cur_time;
    logic           adv;
    logic           fin;

    assign cur      = loaded_reg ? cmd_reg  : head;
    assign cur_rem  = loaded_reg ? rem_reg  : head.nsamp;
    assign cur_sl   = loaded_reg ? sl_reg   : head.sl_start;
    assign cur_time = loaded_reg ? time_reg : head.time_start;

    assign adv = (!ov_reg || out_ready) && (loaded_reg || !stat.empty);
    assign pop = adv && !loaded_reg;

    always_comb
    begin
        res_next = '0;
        res_next.channel = cur.channel;
        if (cur_rem != 5'd0)
        begin
            res_next.kind         = dmld_pkg::KIND_SAMPLE;
            res_next.slot         = cur_sl - 5'd1;
            res_next.timestamp    = cur_time;
            res_next.raw_value    = cur.value;
            res_next.precision    = cur.precision;
            res_next.channel_done = (cur_sl == 5'd1);
            fin = (cur_rem == 5'd1) && !cur.tail_valid;
        end
        else
        begin
            res_next.kind      = cur.tail_kind;
            res_next.raw_value = cur.tail_raw;
            fin = 1'b1;
        end
        res_next.last = fin;
        loaded_next   = !fin;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg  <= res_next;
            rem_reg  <= cur_rem - 5'd1;
            sl_reg   <= cur_sl - 5'd1;
            time_reg <= cur_time - {6'd0, cur.step};
            if (!loaded_reg)
                cmd_reg <= head;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                loaded_reg <= loaded_next;
                ov_reg     <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    assign out_valid = ov_reg;
    assign res       = res_reg;

endmodule

// ----- hdl/delta_measurement_log_decoder.sv -----
// Top level of the delta measurement log decoder.
// Depends on dmld_pkg, dmld_front, dmld_fifo, dmld_back and the defines header.
//
//   channel   dir  width  content
//   s_axis    in   8+1    file byte in tdata, end of file in tlast
//   m_axis    out  56+3+1 result fields in tdata, kind in tuser, last in tlast
//   cfg       in   8      expected version byte
//
// Input: one byte per cycle while the command queue has room.
// Output: one result per cycle while m_axis_tready is high; a byte that
// yields a run of n samples gives n results, plus one for a trailing result.
// The four-entry queue absorbs such runs; input stalls only when it fills.
// Reset: asynchronous, active low; no clearing pass, ready right after reset.
`include "delta_measurement_log_decoder_defines.svh"

module delta_measurement_log_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // end_of_file
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // channel, slot, timestamp, raw_value,
                                        // precision, channel_done
    output logic [2:0]  m_axis_tuser,   // kind
    output logic        m_axis_tlast,   // last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data        // expected_version
);

    logic [7:0]           exp_ver_reg;
    logic                 accept;
    logic                 push;
    logic                 pop;
    dmld_pkg::cmd_t       cmd_in;
    dmld_pkg::cmd_t       cmd_head;
    dmld_pkg::fifo_stat_t fstat;
    dmld_pkg::res_t       res;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !fstat.full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            exp_ver_reg <= 8'd1;
        else if (cfg_valid && cfg_ready)
            exp_ver_reg <= cfg_data;
    end

    dmld_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (accept),
        .data_byte        (s_axis_tdata),
        .end_of_file      (s_axis_tlast),
        .expected_version (exp_ver_reg),
        .push             (push),
        .cmd              (cmd_in)
    );

    dmld_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (cmd_in),
        .pop   (pop),
        .dout  (cmd_head),
        .stat  (fstat)
    );

    dmld_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (cmd_head),
        .stat      (fstat),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .res       (res)
    );

    assign m_axis_tdata = {res.channel_done, res.precision, res.raw_value,
                           res.timestamp, res.slot, res.channel};
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;

    `DMLD_ASSERT_NOW(a_tail_is_last, m_axis_tvalid && m_axis_tuser != dmld_pkg::KIND_SAMPLE, m_axis_tlast)
    `DMLD_ASSERT_NOW(a_done_slot_zero, m_axis_tvalid && m_axis_tuser == dmld_pkg::KIND_SAMPLE && m_axis_tdata[55], m_axis_tdata[12:8] == 5'd0)
    `DMLD_ASSERT_NOW(a_battery_byte, m_axis_tvalid && m_axis_tuser == dmld_pkg::KIND_BATTERY, m_axis_tdata[51:44] == 8'd0)
    `DMLD_ASSERT_NEXT(a_pop_fills_out, pop, m_axis_tvalid)

endmodule
